### sv/ekmf_pkg.sv
// ----------------------------------------------------------------------------
// ekmf_pkg
// Shared types and constants of the max-flow block: widths, store sizes and
// the command/status words between controller and datapath.
// ----------------------------------------------------------------------------
package ekmf_pkg;

   localparam int NODE_W    = 6;
   localparam int MAX_NODES = 64;
   localparam int CAP_W     = 30;
   localparam int FLOW_W    = 40;
   localparam int MAX_ROWS  = 512;               // edge pairs; two entries per row
   localparam int ROW_W     = 9;                 // row index
   localparam int CNT_W     = 10;                // row count, holds MAX_ROWS
   localparam int EDGE_W    = 10;                // entry index {row, reverse bit}
   localparam int QPTR_W    = 7;                 // queue pointer, holds MAX_NODES
   localparam int STEP_W    = 7;                 // walk step counter, holds MAX_NODES
   localparam int NWORD_W   = 2 * NODE_W;        // {to, from}
   localparam int RWORD_W   = 2 * CAP_W;         // {reverse, forward}

   localparam logic [CAP_W-1:0]  PUSH_CAP  = CAP_W'(1000000000);
   localparam logic [CNT_W-1:0]  ROWS_FULL = CNT_W'(MAX_ROWS);
   localparam logic [STEP_W-1:0] STEP_MAX  = STEP_W'(MAX_NODES);

   localparam int CSR_AW = 3;
   localparam logic CSR_SOURCE = 1'b0;           // register select, paddr[2]
   localparam logic CSR_SINK   = 1'b1;

   typedef struct packed {
      logic load_en;       // take edge words
      logic init_search;   // clear marks, enqueue source
      logic deq_read;      // read queue head
      logic node_load;     // latch dequeued node, restart row scan
      logic scan_run;      // scan rows for the current node
      logic walk_start;    // restart path walk at the sink
      logic walk_pass;     // 0: bottleneck pass, 1: update pass
      logic edge_read;     // read the row of the parent edge
      logic walk_upd;      // take min or update residuals, step to origin
      logic flow_add;      // add push to total
      logic emit;          // present result and clear problem
   } ekmf_cmd_type;

   typedef struct packed {
      logic start;         // last edge word accepted
      logic trivial;       // source equals sink
      logic q_empty;
      logic node_is_sink;
      logic scan_done;
      logic sink_seen;
      logic walk_end;
      logic push_zero;
      logic out_free;
   } ekmf_stat_type;

endpackage

### sv/edmonds_karp_max_flow.sv
// ----------------------------------------------------------------------------
// edmonds_karp_max_flow
// Maximum flow by breadth-first augmenting paths over a loaded edge list.
//
//   channel | direction | words
//   req_    | in        | one edge per word; last_edge starts the solve
//   rsp_    | out       | one word per problem: max_flow, edges_dropped
//   csr_    | in        | source_node at 0x0, sink_node at 0x4
//
// Edge words load one per cycle while idle. After the last edge req_stall
// stays high for the solve: each search dequeues nodes and, for each, scans
// all R stored edge pairs, one store row read per cycle, then drains the scan;
// each path is walked hop by hop in two passes, bottleneck then update.
// Reset is synchronous and leaves an empty graph, source 0, sink 63.
// rsp_stall holds the result word; the next problem may load meanwhile.
// ----------------------------------------------------------------------------
module edmonds_karp_max_flow import ekmf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [NODE_W-1:0]  req_from_node,
   input  logic [NODE_W-1:0]  req_to_node,
   input  logic [CAP_W-1:0]   req_capacity,
   input  logic               req_last_edge,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [FLOW_W-1:0]  rsp_max_flow,
   output logic               rsp_edges_dropped,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [CSR_AW-1:0]  csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   logic [NODE_W-1:0] src_ff, snk_ff;
   ekmf_cmd_type      cmd;
   ekmf_stat_type     stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_ff <= '0;
         snk_ff <= NODE_W'(63);
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr[2])
            CSR_SOURCE: src_ff <= csr_pwdata[NODE_W-1:0];
            CSR_SINK:   snk_ff <= csr_pwdata[NODE_W-1:0];
            default:    ;
         endcase
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = {26'd0, (csr_paddr[2] == CSR_SINK) ? snk_ff : src_ff};

   ekmf_ctrl u_ctrl (
      .clock(clock), .reset(reset), .stat(stat), .cmd(cmd));

   ekmf_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .src_node(src_ff), .snk_node(snk_ff),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_from_node(req_from_node), .req_to_node(req_to_node),
      .req_capacity(req_capacity), .req_last_edge(req_last_edge),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_max_flow(rsp_max_flow), .rsp_edges_dropped(rsp_edges_dropped));

endmodule

### sv/ekmf_ram.sv
// ----------------------------------------------------------------------------
// ekmf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ekmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/ekmf_ctrl.sv
// ----------------------------------------------------------------------------
// ekmf_ctrl
// Sequencer for load, breadth-first search, two-pass path walk and result.
// ----------------------------------------------------------------------------
module ekmf_ctrl import ekmf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  ekmf_stat_type stat,
   output ekmf_cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_INIT, ST_DEQ, ST_DEQW, ST_SCAN, ST_CHECK,
      ST_WP, ST_WE, ST_WU, ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      pass_ff, pass_in;

   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load_en = 1'b1;
            if (stat.start) begin
               state_in = stat.trivial ? ST_DONE : ST_INIT;
            end
         end
         ST_INIT: begin
            cmd.init_search = 1'b1;
            state_in = ST_DEQ;
         end
         ST_DEQ: begin
            if (stat.q_empty) begin
               state_in = ST_CHECK;
            end else begin
               cmd.deq_read = 1'b1;
               state_in = ST_DEQW;
            end
         end
         ST_DEQW: begin
            cmd.node_load = 1'b1;
            state_in = stat.node_is_sink ? ST_CHECK : ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (stat.scan_done) begin
               state_in = ST_DEQ;
            end
         end
         ST_CHECK: begin
            if (stat.sink_seen) begin
               cmd.walk_start = 1'b1;
               cmd.walk_pass  = 1'b0;
               pass_in  = 1'b0;
               state_in = ST_WP;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_WP: begin
            if (!stat.walk_end) begin
               state_in = ST_WE;
            end else if (!pass_ff) begin
               cmd.walk_start = 1'b1;
               cmd.walk_pass  = 1'b1;
               pass_in = 1'b1;
            end else begin
               cmd.flow_add = 1'b1;
               state_in = stat.push_zero ? ST_DONE : ST_INIT;
            end
         end
         ST_WE: begin
            cmd.edge_read = 1'b1;
            state_in = ST_WU;
         end
         ST_WU: begin
            cmd.walk_upd  = 1'b1;
            cmd.walk_pass = pass_ff;
            state_in = ST_WP;
         end
         ST_DONE: begin
            cmd.emit = 1'b1;
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pass_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
      end
   end

   a_load_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load_en |-> state_ff == ST_IDLE)
      else $error("load enabled outside idle");
   a_done_after_emit: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && stat.out_free) |=> state_ff == ST_IDLE)
      else $error("emit did not return to idle");
   a_pass_stable_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WE) |=> $stable(pass_ff))
      else $error("walk pass changed mid-step");

endmodule

### sv/ekmf_dp.sv
// ----------------------------------------------------------------------------
// ekmf_dp
// Datapath: edge store (one row per edge pair), search marks, queue,
// parent table, path walk arithmetic, flow total and result register.
// ----------------------------------------------------------------------------
module ekmf_dp import ekmf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  ekmf_cmd_type       cmd,
   output ekmf_stat_type      stat,
   input  logic [NODE_W-1:0]  src_node,
   input  logic [NODE_W-1:0]  snk_node,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [NODE_W-1:0]  req_from_node,
   input  logic [NODE_W-1:0]  req_to_node,
   input  logic [CAP_W-1:0]   req_capacity,
   input  logic               req_last_edge,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [FLOW_W-1:0]  rsp_max_flow,
   output logic               rsp_edges_dropped
);

   logic [CNT_W-1:0]     rows_ff, rows_in;
   logic                 ovf_ff, ovf_in;
   logic [FLOW_W-1:0]    flow_ff, flow_in;
   logic [MAX_NODES-1:0] vis_ff, vis_in;
   logic [QPTR_W-1:0]    head_ff, head_in, tail_ff, tail_in;
   logic [NODE_W-1:0]    node_ff, node_in;
   logic [CNT_W-1:0]     scan_ff, scan_in;
   logic                 rdv_ff, rdv_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [NODE_W-1:0]    wnode_ff, wnode_in;
   logic [STEP_W-1:0]    steps_ff, steps_in;
   logic [CAP_W-1:0]     push_ff, push_in;
   logic [EDGE_W-1:0]    edge_ff, edge_in;
   logic                 rv_ff, rv_in;
   logic [FLOW_W-1:0]    out_flow_ff, out_flow_in;
   logic                 out_drop_ff, out_drop_in;

   // store ports
   logic                 st_we;
   logic [ROW_W-1:0]     st_waddr, st_raddr;
   logic [NWORD_W-1:0]   nw_wdata, nw_rdata;
   logic [RWORD_W-1:0]   rw_wdata, rw_rdata;
   logic                 q_we;
   logic [NODE_W-1:0]    q_waddr, q_wdata, q_rdata;
   logic                 p_we;
   logic [NODE_W-1:0]    p_waddr;
   logic [EDGE_W-1:0]    p_wdata, p_rdata;

   logic                 accept, store_ok, out_free;
   logic [NODE_W-1:0]    e_from, e_to, w_org;
   logic [CAP_W-1:0]     r_fwd, r_rev, w_res;
   logic                 fwd_hit, rev_hit;

   assign accept    = req_valid && cmd.load_en;
   assign req_stall = !cmd.load_en;
   assign store_ok  = rows_ff != ROWS_FULL;
   assign out_free  = !rv_ff || !rsp_stall;

   assign e_from = nw_rdata[NODE_W-1:0];
   assign e_to   = nw_rdata[NWORD_W-1:NODE_W];
   assign r_fwd  = rw_rdata[CAP_W-1:0];
   assign r_rev  = rw_rdata[RWORD_W-1:CAP_W];
   assign w_org  = edge_ff[0] ? e_to : e_from;
   assign w_res  = edge_ff[0] ? r_rev : r_fwd;

   // at most one of the pair can leave the current node to an unmarked node
   assign fwd_hit = rdv_ff && e_from == node_ff && r_fwd != '0 && !vis_ff[e_to];
   assign rev_hit = rdv_ff && e_to == node_ff && r_rev != '0 && !vis_ff[e_from];

   always_comb begin
      rows_in  = rows_ff;   ovf_in   = ovf_ff;   flow_in  = flow_ff;
      vis_in   = vis_ff;    head_in  = head_ff;  tail_in  = tail_ff;
      node_in  = node_ff;   scan_in  = scan_ff;  rdv_in   = 1'b0;
      row_in   = row_ff;    wnode_in = wnode_ff; steps_in = steps_ff;
      push_in  = push_ff;   edge_in  = edge_ff;  rv_in    = rv_ff;
      out_flow_in = out_flow_ff;  out_drop_in = out_drop_ff;
      st_we = 1'b0;  st_waddr = rows_ff[ROW_W-1:0];
      nw_wdata = {req_to_node, req_from_node};
      rw_wdata = {CAP_W'(0), req_capacity};
      st_raddr = scan_ff[ROW_W-1:0];
      q_we = 1'b0;  q_waddr = tail_ff[NODE_W-1:0];  q_wdata = src_node;
      p_we = 1'b0;  p_waddr = e_to;  p_wdata = {row_ff, 1'b0};

      if (rv_ff && !rsp_stall) begin
         rv_in = 1'b0;
      end

      if (accept) begin
         if (store_ok) begin
            st_we   = 1'b1;
            rows_in = rows_ff + CNT_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end

      if (cmd.init_search) begin
         vis_in  = '0;
         vis_in[src_node] = 1'b1;
         q_we    = 1'b1;
         q_waddr = '0;
         head_in = '0;
         tail_in = QPTR_W'(1);
      end

      if (cmd.deq_read) begin
         head_in = head_ff + QPTR_W'(1);
      end

      if (cmd.node_load) begin
         node_in = q_rdata;
         scan_in = '0;
      end

      if (cmd.scan_run) begin
         if (scan_ff < rows_ff) begin
            rdv_in  = 1'b1;
            row_in  = scan_ff[ROW_W-1:0];
            scan_in = scan_ff + CNT_W'(1);
         end
         if (fwd_hit || rev_hit) begin
            if (fwd_hit) begin
               vis_in[e_to] = 1'b1;
            end else begin
               vis_in[e_from] = 1'b1;
               p_waddr = e_from;
               p_wdata = {row_ff, 1'b1};
            end
            p_we = 1'b1;
            q_wdata = fwd_hit ? e_to : e_from;
            if (tail_ff < QPTR_W'(MAX_NODES)) begin
               q_we    = 1'b1;
               tail_in = tail_ff + QPTR_W'(1);
            end
         end
      end

      if (cmd.walk_start) begin
         wnode_in = snk_node;
         steps_in = '0;
         if (!cmd.walk_pass) begin
            push_in = PUSH_CAP;
         end
      end

      if (cmd.edge_read) begin
         edge_in  = p_rdata;
      end
      if (cmd.edge_read) begin
         st_raddr = p_rdata[EDGE_W-1:1];
      end

      if (cmd.walk_upd) begin
         if (!cmd.walk_pass) begin
            if (w_res < push_ff) begin
               push_in = w_res;
            end
         end else begin
            st_we    = 1'b1;
            st_waddr = edge_ff[EDGE_W-1:1];
            rw_wdata = edge_ff[0] ? {r_rev - push_ff, r_fwd + push_ff}
                                  : {r_rev + push_ff, r_fwd - push_ff};
         end
         wnode_in = w_org;
         steps_in = steps_ff + STEP_W'(1);
      end

      if (cmd.flow_add) begin
         flow_in = flow_ff + FLOW_W'(push_ff);
      end

      if (cmd.emit && out_free) begin
         rv_in       = 1'b1;
         out_flow_in = flow_ff;
         out_drop_in = ovf_ff;
         rows_in     = '0;
         flow_in     = '0;
         ovf_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= '0;
         ovf_ff  <= 1'b0;
         flow_ff <= '0;
         vis_ff  <= '0;
         head_ff <= '0;
         tail_ff <= '0;
         rdv_ff  <= 1'b0;
         rv_ff   <= 1'b0;
      end else begin
         rows_ff <= rows_in;
         ovf_ff  <= ovf_in;
         flow_ff <= flow_in;
         vis_ff  <= vis_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         rdv_ff  <= rdv_in;
         rv_ff   <= rv_in;
      end
      node_ff     <= node_in;
      scan_ff     <= scan_in;
      row_ff      <= row_in;
      wnode_ff    <= wnode_in;
      steps_ff    <= steps_in;
      push_ff     <= push_in;
      edge_ff     <= edge_in;
      out_flow_ff <= out_flow_in;
      out_drop_ff <= out_drop_in;
   end

   ekmf_ram #(.WIDTH(NWORD_W), .DEPTH(MAX_ROWS)) u_node_ram (
      .clock(clock), .wr_en(st_we && accept), .wr_addr(st_waddr), .wr_data(nw_wdata),
      .rd_addr(st_raddr), .rd_data(nw_rdata));

   ekmf_ram #(.WIDTH(RWORD_W), .DEPTH(MAX_ROWS)) u_res_ram (
      .clock(clock), .wr_en(st_we), .wr_addr(st_waddr), .wr_data(rw_wdata),
      .rd_addr(st_raddr), .rd_data(rw_rdata));

   ekmf_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue_ram (
      .clock(clock), .wr_en(q_we), .wr_addr(q_waddr), .wr_data(q_wdata),
      .rd_addr(head_ff[NODE_W-1:0]), .rd_data(q_rdata));

   ekmf_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_NODES)) u_parent_ram (
      .clock(clock), .wr_en(p_we), .wr_addr(p_waddr), .wr_data(p_wdata),
      .rd_addr(wnode_ff), .rd_data(p_rdata));

   assign stat.start        = accept && req_last_edge;
   assign stat.trivial      = src_node == snk_node;
   assign stat.q_empty      = head_ff >= tail_ff;
   assign stat.node_is_sink = q_rdata == snk_node;
   assign stat.scan_done    = scan_ff >= rows_ff && !rdv_ff;
   assign stat.sink_seen    = vis_ff[snk_node];
   assign stat.walk_end     = wnode_ff == src_node || steps_ff == STEP_MAX;
   assign stat.push_zero    = push_ff == '0;
   assign stat.out_free     = out_free;

   assign rsp_valid         = rv_ff;
   assign rsp_max_flow      = out_flow_ff;
   assign rsp_edges_dropped = out_drop_ff;

   a_rows_bound: assert property (@(posedge clock) disable iff (reset)
      rows_ff <= ROWS_FULL)
      else $error("row count beyond store");
   a_head_tail: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff)
      else $error("queue head passed tail");
   a_scan_row: assert property (@(posedge clock) disable iff (reset)
      rdv_ff |-> CNT_W'(row_ff) < rows_ff)
      else $error("scan read beyond stored rows");
   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && out_free) |=> (rows_ff == '0 && rv_ff))
      else $error("result emit did not clear problem");

endmodule

### test/tb_edmonds_karp_max_flow.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_edmonds_karp_max_flow
// Loads random and directed flow networks edge by edge, predicts the maximum
// flow with a local breadth-first augmenting-path solver and checks each
// result word against it, under random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_edmonds_karp_max_flow;
   import ekmf_pkg::*;

   localparam int DEPTH     = 2 * MAX_ROWS;
   localparam int CYCLE_LIM = 40000000;
   localparam logic [CSR_AW-1:0] ADDR_SOURCE = 3'h0;
   localparam logic [CSR_AW-1:0] ADDR_SINK   = 3'h4;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_stall;
   logic [NODE_W-1:0] req_from_node = '0, req_to_node = '0;
   logic [CAP_W-1:0] req_capacity = '0;
   logic req_last_edge = 1'b0;
   logic rsp_valid, rsp_stall = 1'b0;
   logic [FLOW_W-1:0] rsp_max_flow;
   logic rsp_edges_dropped;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0, csr_prdata;
   logic csr_pready;

   edmonds_karp_max_flow u_top (.*);

   always #5 clock = ~clock;

   typedef struct {
      logic [FLOW_W-1:0] flow;
      logic              dropped;
   } flow_word_type;

   // solver copy of the block state
   logic [NODE_W-1:0] src_reg, snk_reg;
   logic [NODE_W-1:0] g_from [DEPTH];
   logic [NODE_W-1:0] g_to   [DEPTH];
   logic [CAP_W-1:0]  g_res  [DEPTH];
   int                g_cnt;
   logic              g_full;
   flow_word_type     flow_expected[$];
   bit                failed = 0;
   int                cycles = 0;
   bit                rsp_gaps = 1;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIM) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic bit bfs(output int par[MAX_NODES]);
      bit seen[MAX_NODES];
      int q[$];
      int n;
      foreach (seen[i]) seen[i] = 0;
      seen[src_reg] = 1;
      q.insert(q.size(), int'(src_reg));
      while (q.size() > 0) begin
         n = q.pop_front();
         if (n == snk_reg) break;
         for (int e = 0; e < g_cnt; e++)
            if (g_from[e] == n && g_res[e] != 0 && !seen[g_to[e]]) begin
               seen[g_to[e]] = 1;
               par[g_to[e]] = e;
               q.insert(q.size(), int'(g_to[e]));
            end
      end
      return seen[snk_reg];
   endfunction

   function automatic logic [FLOW_W-1:0] max_flow_of();
      int par[MAX_NODES];
      logic [FLOW_W-1:0] total = '0;
      logic [CAP_W-1:0] push;
      int n, e;
      if (src_reg == snk_reg) return '0;
      while (bfs(par)) begin
         push = PUSH_CAP;
         n = snk_reg;
         while (n != src_reg) begin
            e = par[n];
            if (g_res[e] < push) push = g_res[e];
            n = g_from[e];
         end
         n = snk_reg;
         while (n != src_reg) begin
            e = par[n];
            g_res[e] -= push;
            g_res[e ^ 1] += push;
            n = g_from[e];
         end
         total = total + FLOW_W'(push);
         if (push == 0) break;
      end
      return total;
   endfunction

   function automatic void predict_edge(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                                        logic [CAP_W-1:0] cap, logic last);
      flow_word_type w;
      if (g_cnt + 2 > DEPTH) g_full = 1;
      else begin
         g_from[g_cnt] = a;  g_to[g_cnt] = b;  g_res[g_cnt] = cap;
         g_from[g_cnt+1] = b; g_to[g_cnt+1] = a; g_res[g_cnt+1] = '0;
         g_cnt += 2;
      end
      if (last) begin
         w.flow = max_flow_of();
         w.dropped = g_full;
         flow_expected.insert(flow_expected.size(), w);
         g_cnt = 0;
         g_full = 0;
      end
   endfunction

   function automatic int gap();
      return ($urandom_range(0, 15) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
   endfunction

   // result checker with random stall
   always @(posedge clock) begin
      flow_word_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (flow_expected.size() == 0) begin
            $display("%0t: unexpected word flow=%0d dropped=%0b", $time, rsp_max_flow,
                     rsp_edges_dropped);
            failed = 1;
         end else begin
            w = flow_expected.pop_front();
            if (rsp_max_flow !== w.flow) begin
               $display("%0t: max_flow expected %0d actual %0d", $time, w.flow,
                        rsp_max_flow);
               failed = 1;
            end
            if (rsp_edges_dropped !== w.dropped) begin
               $display("%0t: edges_dropped expected %0b actual %0b", $time, w.dropped,
                        rsp_edges_dropped);
               failed = 1;
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= rsp_gaps && ($urandom_range(0, 3) == 0);
   end

   task automatic send_edge(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                            logic [CAP_W-1:0] cap, logic last);
      int g;
      g = gap();
      if ($urandom_range(0, 3) == 0) g = 0;
      repeat (g) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_from_node <= a;
      req_to_node <= b;
      req_capacity <= cap;
      req_last_edge <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_edge(a, b, cap, last);
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic drain();
      while (flow_expected.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_AW-1:0] addr, logic [31:0] data);
      @(negedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= addr; csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (addr == ADDR_SOURCE) src_reg = data[NODE_W-1:0];
      else snk_reg = data[NODE_W-1:0];
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
   endtask

   task automatic set_terminals(int s, int t);
      drain();
      csr_write(ADDR_SOURCE, s);
      csr_write(ADDR_SINK, t);
   endtask

   // random graph; mostly small, with paths biased from source toward sink
   task automatic send_graph(int n_edges, int n_nodes);
      logic [NODE_W-1:0] a, b;
      logic [CAP_W-1:0] cap;
      for (int i = 0; i < n_edges; i++) begin
         a = NODE_W'($urandom_range(0, n_nodes - 1));
         b = NODE_W'($urandom_range(0, n_nodes - 1));
         if ($urandom_range(0, 5) == 0) a = src_reg;
         if ($urandom_range(0, 5) == 0) b = snk_reg;
         case ($urandom_range(0, 4))
            0: cap = CAP_W'($urandom);
            1: cap = '0;
            2: cap = CAP_W'($urandom_range(999999990, 1000000010));
            default: cap = CAP_W'($urandom_range(1, 100));
         endcase
         send_edge(a, b, cap, i == n_edges - 1);
      end
   endtask

   task automatic test_directed();
      set_terminals(0, 63);
      send_edge(0, 63, 30'h3FFFFFFF, 1);       // push capped at 1e9
      send_edge(0, 1, 5, 0);
      send_edge(1, 63, 7, 0);
      send_edge(0, 2, 4, 0);
      send_edge(2, 1, 9, 0);
      send_edge(2, 63, 0, 1);
      send_edge(63, 0, 100, 1);                 // wrong direction
      set_terminals(5, 5);                      // source equals sink
      send_edge(5, 6, 10, 0);
      send_edge(6, 5, 10, 1);
      set_terminals(63, 0);
      send_edge(63, 0, 1000000000, 0);
      send_edge(63, 0, 1000000000, 1);
      send_edge(0, 0, 3, 1);                    // self loop only
   endtask

   task automatic test_store_full();
      set_terminals(0, 63);
      for (int i = 0; i < MAX_ROWS + 3; i++)
         send_edge(NODE_W'(i % 2 ? 0 : 40), NODE_W'(i % 2 ? 40 : 63), CAP_W'(i + 1),
                   i == MAX_ROWS + 2);
   endtask

   task automatic test_random();
      int sent = 0;
      int k;
      while (sent < 1500) begin
         if ($urandom_range(0, 9) == 0)
            set_terminals($urandom_range(0, 63), $urandom_range(0, 63));
         if ($urandom_range(0, 19) == 0) begin
            drain();                            // sender waits for every result
            rsp_gaps = 1'($urandom_range(0, 1));
         end
         k = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
         send_graph(k, $urandom_range(0, 3) == 0 ? 64 : $urandom_range(2, 8));
         sent += k;
      end
      rsp_gaps = 1;
   endtask

   initial begin
      src_reg = 0;
      snk_reg = 63;
      g_cnt = 0;
      g_full = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_store_full();
      test_random();
      drain();
      if (!failed) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
